// ===== rtl/core/dslc_pkg.sv =====
// Shared types and constants of the depth sorted layer compositor.
// Used by dslc_ctrl, dslc_datapath and the top level; depends on nothing.
`default_nettype none
package dslc_pkg;

   localparam int FRAC_BITS = 24;
   localparam logic [24:0] FRAC_ONE = 25'h100_0000;
   localparam int DIV_STEPS = 49;

   typedef enum logic [1:0] {
      MODE_NORMAL   = 2'd0,
      MODE_MULTIPLY = 2'd1,
      MODE_SCREEN   = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_PICK_INIT,
      OP_SCAN,
      OP_EVAL,
      OP_MUL1,
      OP_MUL2,
      OP_MUL3,
      OP_DIV,
      OP_MUL4,
      OP_WB,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   accept;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic picks_done;
      logic alpha_zero;
      logic div_last;
   } status_type;

   // floor(v * 2^24 / 65535)
   function automatic logic [24:0] to_frac(input logic [15:0] v);
      logic [7:0]  q0;
      logic [16:0] r;
      logic [8:0]  q;
      begin
         q0 = v[15:8];
         r  = {1'b0, v[7:0], 8'h00} + {9'h000, q0};
         q  = {1'b0, q0} + ((r >= 17'd65535) ? 9'd1 : 9'd0);
         to_frac = {1'b0, v, 8'h00} + {16'h0000, q};
      end
   endfunction

   // min((f * 65535) >> 24, 65535)
   function automatic logic [15:0] from_frac(input logic [29:0] f);
      logic [45:0] p;
      begin
         p = {f, 16'h0000} - {16'h0000, f};
         from_frac = (p[45:40] != 6'd0) ? 16'hFFFF : p[39:24];
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dslc_ctrl.sv =====
// Sequencer of the compositor: collect, sort scan, composite steps, result.
// Depends on dslc_pkg; drives dslc_datapath through cmd and reads its status.
`default_nettype none
module dslc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic                req_tlast,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output dslc_pkg::cmd_type        cmd,
   input  wire dslc_pkg::status_type status
);

   typedef enum logic [10:0] {
      S_COLLECT = 11'b000_0000_0001,
      S_NEXT    = 11'b000_0000_0010,
      S_SCAN_RD = 11'b000_0000_0100,
      S_SCAN    = 11'b000_0000_1000,
      S_EVAL    = 11'b000_0001_0000,
      S_MUL1    = 11'b000_0010_0000,
      S_MUL2    = 11'b000_0100_0000,
      S_MUL3    = 11'b000_1000_0000,
      S_DIV     = 11'b001_0000_0000,
      S_MUL4    = 11'b010_0000_0000,
      S_WB      = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      finish_ff, finish_in;
   logic      accept;

   assign req_tready = (state_ff == S_COLLECT) && !finish_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      finish_in    = finish_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = dslc_pkg::OP_NONE;
      cmd.accept   = accept;
      unique case (state_ff)
         S_COLLECT: begin
            if (finish_ff) begin
               if (!rsp_valid_ff || rsp_tready) begin
                  cmd.op       = dslc_pkg::OP_OUT;
                  rsp_valid_in = 1'b1;
                  finish_in    = 1'b0;
               end
            end else if (accept && req_tlast) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            cmd.op = dslc_pkg::OP_PICK_INIT;
            if (status.picks_done) begin
               state_in  = S_COLLECT;
               finish_in = 1'b1;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: state_in = S_SCAN;
         S_SCAN: begin
            cmd.op   = dslc_pkg::OP_SCAN;
            state_in = status.scan_last ? S_EVAL : S_SCAN_RD;
         end
         S_EVAL: begin
            cmd.op   = dslc_pkg::OP_EVAL;
            state_in = status.alpha_zero ? S_NEXT : S_MUL1;
         end
         S_MUL1: begin
            cmd.op   = dslc_pkg::OP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op   = dslc_pkg::OP_MUL2;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            cmd.op   = dslc_pkg::OP_MUL3;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = dslc_pkg::OP_DIV;
            if (status.div_last) state_in = S_MUL4;
         end
         S_MUL4: begin
            cmd.op   = dslc_pkg::OP_MUL4;
            state_in = S_WB;
         end
         S_WB: begin
            cmd.op   = dslc_pkg::OP_WB;
            state_in = S_NEXT;
         end
         default: state_in = S_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         rsp_valid_ff <= 1'b0;
         finish_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         finish_ff    <= finish_in;
      end
   end

   a_ready_only_collect: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == S_COLLECT))
      else $error("input taken outside collect");
   a_div_to_mul4: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && status.div_last) |=> (state_ff == S_MUL4))
      else $error("divider exit lost");
   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == dslc_pkg::OP_OUT) |=> rsp_valid_ff)
      else $error("result not raised");

endmodule
`default_nettype wire

// ===== rtl/core/dslc_datapath.sv =====
// Layer store, depth scan, blend arithmetic and divider of the compositor.
// Depends on dslc_pkg; commanded by dslc_ctrl.
`default_nettype none
module dslc_datapath #(
   parameter int MAX_LAYERS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dslc_pkg::cmd_type    cmd,
   output dslc_pkg::status_type      status,
   input  wire logic [87:0]          req_tdata,
   input  wire logic                 csr_wr_en,
   input  wire logic                 csr_wr_data,
   input  wire logic                 req_tlast,
   output logic [63:0]               rsp_tdata,
   output logic                      rsp_tuser
);

   localparam int IW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int CW = $clog2(MAX_LAYERS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LAYERS);
   localparam logic [CW-1:0] ONE_CNT = CW'(1);

   logic [63:0] col_mem   [MAX_LAYERS];
   logic [15:0] depth_mem [MAX_LAYERS];
   logic [1:0]  mode_mem  [MAX_LAYERS];

   logic [63:0] rd_col_ff;
   logic [15:0] rd_depth_ff;
   logic [1:0]  rd_mode_ff;

   logic [CW-1:0] cnt_ff, k_ff, scan_ff, prev_idx_ff, best_idx_ff;
   logic          ovf_ff, inv_ff, csr_inv_ff, found_ff;
   logic [15:0]   prev_kd_ff, best_kd_ff;
   logic [63:0]   best_col_ff, acc_ff;
   logic [1:0]    best_mode_ff, mode_ff;

   logic [24:0] da_ff, sa_ff;
   logic [24:0] sr_ff [3];
   logic [24:0] dr_ff [3];
   logic [49:0] oa_p_ff;
   logic [49:0] prod_ff [3];
   logic [25:0] oa_ff;
   logic [25:0] blend_ff [3];
   logic [49:0] t1_ff [3];
   logic [50:0] t2_ff [3];
   logic [27:0] inner_ff [3];
   logic [49:0] u1_ff [3];
   logic [52:0] u2_ff [3];
   logic [25:0] rem_ff;
   logic [48:0] num_ff;
   logic [24:0] quo_ff;
   logic [5:0]  div_cnt_ff;
   logic [63:0] out_ff;
   logic        out_drop_ff;

   logic          store;
   logic [15:0]   kd;
   logic          eligible, better;
   logic [25:0]   oa_new;
   logic [26:0]   rem_sh;
   logic          ge;
   logic [24:0]   ratio;

   assign store = cmd.accept && (cnt_ff < MAX_CNT);
   assign kd    = inv_ff ? ~rd_depth_ff : rd_depth_ff;
   assign eligible = (k_ff == '0) || (kd > prev_kd_ff) ||
                     ((kd == prev_kd_ff) && (scan_ff > prev_idx_ff));
   assign better   = !found_ff || (kd < best_kd_ff);
   assign oa_new   = {1'b0, da_ff} + oa_p_ff[49:24];
   assign rem_sh   = {rem_ff, num_ff[48]};
   assign ge       = rem_sh >= {1'b0, oa_ff};
   assign ratio    = (quo_ff > dslc_pkg::FRAC_ONE) ? dslc_pkg::FRAC_ONE : quo_ff;

   assign status.scan_last  = (scan_ff == (cnt_ff - ONE_CNT));
   assign status.picks_done = (k_ff == cnt_ff);
   assign status.alpha_zero = (best_col_ff[63:48] == 16'h0000);
   assign status.div_last   = (div_cnt_ff == 6'(dslc_pkg::DIV_STEPS - 1));

   assign rsp_tdata = out_ff;
   assign rsp_tuser = out_drop_ff;

   always_ff @(posedge clock) begin
      if (store) begin
         col_mem[cnt_ff[IW-1:0]]   <= req_tdata[63:0];
         depth_mem[cnt_ff[IW-1:0]] <= req_tdata[79:64];
         mode_mem[cnt_ff[IW-1:0]]  <= req_tdata[81:80];
      end
      rd_col_ff   <= col_mem[scan_ff[IW-1:0]];
      rd_depth_ff <= depth_mem[scan_ff[IW-1:0]];
      rd_mode_ff  <= mode_mem[scan_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
         csr_inv_ff <= 1'b0;
         k_ff       <= '0;
         acc_ff     <= '0;
      end else begin
         if (csr_wr_en) csr_inv_ff <= csr_wr_data;
         if (cmd.accept) begin
            if (store) cnt_ff <= cnt_ff + ONE_CNT;
            else       ovf_ff <= 1'b1;
            if (req_tlast) begin
               k_ff   <= '0;
               acc_ff <= '0;
            end
         end
         if (cmd.op == dslc_pkg::OP_EVAL) k_ff <= k_ff + ONE_CNT;
         if (cmd.op == dslc_pkg::OP_WB) begin
            for (int c = 0; c < 3; c++) begin
               acc_ff[16*c +: 16] <= dslc_pkg::from_frac(29'(0) +
                  30'((({4'h0, u1_ff[c]} + {1'b0, u2_ff[c]}) >> 24)));
            end
            acc_ff[63:48] <= dslc_pkg::from_frac({4'h0, oa_ff});
         end
         if (cmd.op == dslc_pkg::OP_OUT) begin
            cnt_ff <= '0;
            ovf_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_tlast) inv_ff <= csr_inv_ff;
      case (cmd.op)
         dslc_pkg::OP_PICK_INIT: begin
            scan_ff  <= '0;
            found_ff <= 1'b0;
         end
         dslc_pkg::OP_SCAN: begin
            if (eligible && better) begin
               found_ff     <= 1'b1;
               best_kd_ff   <= kd;
               best_idx_ff  <= scan_ff;
               best_col_ff  <= rd_col_ff;
               best_mode_ff <= rd_mode_ff;
            end
            scan_ff <= scan_ff + ONE_CNT;
         end
         dslc_pkg::OP_EVAL: begin
            prev_kd_ff  <= best_kd_ff;
            prev_idx_ff <= best_idx_ff;
            mode_ff     <= (k_ff == '0) ? dslc_pkg::MODE_NORMAL : best_mode_ff;
            da_ff       <= dslc_pkg::to_frac(best_col_ff[63:48]);
            sa_ff       <= dslc_pkg::to_frac(acc_ff[63:48]);
            for (int c = 0; c < 3; c++) begin
               sr_ff[c] <= dslc_pkg::to_frac(acc_ff[16*c +: 16]);
               dr_ff[c] <= dslc_pkg::to_frac(best_col_ff[16*c +: 16]);
            end
         end
         dslc_pkg::OP_MUL1: begin
            oa_p_ff <= sa_ff * (dslc_pkg::FRAC_ONE - da_ff);
            for (int c = 0; c < 3; c++) prod_ff[c] <= sr_ff[c] * dr_ff[c];
         end
         dslc_pkg::OP_MUL2: begin
            oa_ff      <= oa_new;
            rem_ff     <= '0;
            num_ff     <= {da_ff, 24'h000000};
            quo_ff     <= '0;
            div_cnt_ff <= '0;
            for (int c = 0; c < 3; c++) begin
               case (mode_ff)
                  dslc_pkg::MODE_MULTIPLY: blend_ff[c] <= prod_ff[c][49:24];
                  dslc_pkg::MODE_SCREEN:
                     blend_ff[c] <= {1'b0, sr_ff[c]} + {1'b0, dr_ff[c]} -
                                    prod_ff[c][49:24];
                  default: blend_ff[c] <= {1'b0, dr_ff[c]};
               endcase
            end
         end
         dslc_pkg::OP_MUL3: begin
            for (int c = 0; c < 3; c++) begin
               t1_ff[c] <= (dslc_pkg::FRAC_ONE - sa_ff) * dr_ff[c];
               t2_ff[c] <= sa_ff * blend_ff[c];
            end
         end
         dslc_pkg::OP_DIV: begin
            rem_ff     <= ge ? 26'(rem_sh - {1'b0, oa_ff}) : rem_sh[25:0];
            num_ff     <= {num_ff[47:0], 1'b0};
            quo_ff     <= {quo_ff[23:0], ge};
            div_cnt_ff <= div_cnt_ff + 6'd1;
            for (int c = 0; c < 3; c++) begin
               inner_ff[c] <= 28'(({2'b00, t1_ff[c]} + {1'b0, t2_ff[c]}) >> 24);
            end
         end
         dslc_pkg::OP_MUL4: begin
            for (int c = 0; c < 3; c++) begin
               u1_ff[c] <= (dslc_pkg::FRAC_ONE - ratio) * sr_ff[c];
               u2_ff[c] <= ratio * inner_ff[c];
            end
         end
         dslc_pkg::OP_OUT: begin
            out_ff      <= acc_ff;
            out_drop_ff <= ovf_ff;
         end
         default: ;
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("layer count beyond store");
   a_pick_found: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == dslc_pkg::OP_EVAL) |-> found_ff)
      else $error("scan found no layer");
   a_picks_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == dslc_pkg::OP_EVAL) |-> (k_ff < cnt_ff))
      else $error("too many picks");

endmodule
`default_nettype wire

// ===== rtl/core/depth_sorted_layer_compositor.sv =====
// Top level of the depth sorted layer compositor.
// Depends on dslc_pkg, dslc_ctrl and dslc_datapath.
//
// Layers of one pixel arrive one beat each, the pixel ending at the beat with
// req_tlast; up to MAX_LAYERS are kept, further ones are dropped and flagged
// in rsp_tuser. After the last beat the layers are picked in stable depth
// order by a full scan of the store for each pick, and each visible layer is
// blended with the 49-step bit-serial alpha divider; a transparent layer
// costs only its scan. The result sits in an output register, so the next
// pixel is taken while it waits.
`default_nettype none
module depth_sorted_layer_compositor #(
   parameter int MAX_LAYERS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [87:0] req_tdata,   // red, green, blue, opacity, depth, mode, zero pad
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // out_red, out_green, out_blue, out_opacity
   output logic             rsp_tuser,   // layers_dropped
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data  // invert_depth_order
);

   dslc_pkg::cmd_type    cmd;
   dslc_pkg::status_type status;

   dslc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   dslc_datapath #(
      .MAX_LAYERS (MAX_LAYERS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tlast   (req_tlast),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== tb/depth_sorted_layer_compositor_test.sv =====
// Self-checking bench for depth_sorted_layer_compositor: random and directed layer stacks,
// a built-in sort-and-blend predictor, stall and hold-off pressure on both stream sides.
// Depends on dslc_pkg and the RTL of the compositor.
module depth_sorted_layer_compositor_test;

   localparam int STORE_DEPTH = 16;
   localparam longint unsigned ONE = 64'd1 << 24;

   typedef struct {
      logic [15:0]        red;
      logic [15:0]        green;
      logic [15:0]        blue;
      logic [15:0]        opacity;
      logic [15:0]        depth;
      dslc_pkg::mode_type mode;
   } layer_type;

   class pixel_scoreboard;
      typedef struct {
         logic [63:0] color;
         logic        dropped;
      } pixel_type;

      layer_type stack[$];
      pixel_type pending_pixels[$];
      bit     overflow;
      bit     invert;
      int     errors;
      int     pixels;
      int     drop_pixels;
      int     layers;

      function longint unsigned frac(logic [15:0] v);
         return ({48'd0, v} << 24) / 64'd65535;
      endfunction

      function logic [15:0] unfrac(longint unsigned f);
         longint unsigned v;
         v = (f * 64'd65535) >> 24;
         return (v > 64'd65535) ? 16'hFFFF : v[15:0];
      endfunction

      function logic [15:0] chan(layer_type l, int c);
         case (c)
            0: return l.red;
            1: return l.green;
            2: return l.blue;
            default: return l.opacity;
         endcase
      endfunction

      function bit ahead(int a, int b);
         if (invert) return stack[a].depth > stack[b].depth;
         return stack[a].depth < stack[b].depth;
      endfunction

      function logic [63:0] blend_stack();
         int order[$];
         int i, j, key, c;
         longint unsigned da, sa, oa, ratio, sr, dr, prod, bl, inr, o;
         logic [15:0] acc[4];
         logic [15:0] nxt[4];
         dslc_pkg::mode_type m;
         layer_type l;
         for (i = 0; i < stack.size(); i++) order.push_back(i);
         for (i = 1; i < stack.size(); i++) begin
            key = order[i];
            j = i;
            while (j > 0 && ahead(key, order[j-1])) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = key;
         end
         acc = '{default: 16'd0};
         for (i = 0; i < order.size(); i++) begin
            l = stack[order[i]];
            da = frac(l.opacity);
            if (da == 0) continue;
            sa = frac(acc[3]);
            oa = da + ((sa * (ONE - da)) >> 24);
            ratio = (da << 24) / oa;
            if (ratio > ONE) ratio = ONE;
            m = (i == 0) ? dslc_pkg::MODE_NORMAL : l.mode;
            for (c = 0; c < 3; c++) begin
               sr = frac(acc[c]);
               dr = frac(chan(l, c));
               prod = (sr * dr) >> 24;
               if (m == dslc_pkg::MODE_MULTIPLY) bl = prod;
               else if (m == dslc_pkg::MODE_SCREEN) bl = sr + dr - prod;
               else bl = dr;
               inr = ((ONE - sa) * dr + sa * bl) >> 24;
               o = ((ONE - ratio) * sr + ratio * inr) >> 24;
               nxt[c] = unfrac(o);
            end
            nxt[3] = unfrac(oa);
            acc = nxt;
         end
         return {acc[3], acc[2], acc[1], acc[0]};
      endfunction

      function void note_layer(layer_type l, bit last);
         pixel_type p;
         layers++;
         if (stack.size() < STORE_DEPTH) stack.push_back(l);
         else overflow = 1;
         if (!last) return;
         p.color = blend_stack();
         p.dropped = overflow;
         pending_pixels.push_back(p);
         pixels++;
         if (overflow) drop_pixels++;
         stack.delete();
         overflow = 0;
      endfunction

      function void check_result(logic [63:0] color, logic dropped);
         pixel_type p;
         int c;
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, actual %h/%b",
                     $time, color, dropped);
            errors++;
            return;
         end
         p = pending_pixels.pop_front();
         for (c = 0; c < 4; c++)
            if (color[16*c +: 16] !== p.color[16*c +: 16]) begin
               $display("%0t: channel %0d mismatch: expected %h, actual %h",
                        $time, c, p.color[16*c +: 16], color[16*c +: 16]);
               errors++;
            end
         if (dropped !== p.dropped) begin
            $display("%0t: layers_dropped mismatch: expected %b, actual %b",
                     $time, p.dropped, dropped);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_pixels.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;    // red, green, blue, opacity, depth, mode, zero pad
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // out_red, out_green, out_blue, out_opacity
   logic        rsp_tuser;         // layers_dropped
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0; // invert_depth_order

   pixel_scoreboard sb = new();
   bit idle_on = 1'b1;
   int hold_left = 0;
   int gap_left = 0;

   depth_sorted_layer_compositor u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("depth_sorted_layer_compositor_test: done, errors");
      $finish;
   end

   // result side: check each beat, then pick the next tready
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 11);
         end
      end
   end

   task automatic send_layer(layer_type l, bit last);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, l.mode, l.depth, l.opacity, l.blue, l.green, l.red};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_layer(l, last);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clock);
   endtask

   task automatic set_invert(bit v);
      drain();
      repeat (2000) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.invert = v;
   endtask

   function automatic logic [15:0] rand_chan();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic layer_type rand_layer();
      layer_type l;
      l.red   = rand_chan();
      l.green = rand_chan();
      l.blue  = rand_chan();
      l.opacity = rand_chan();
      l.depth = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : rand_chan();
      l.mode  = dslc_pkg::mode_type'($urandom_range(0, 3));
      return l;
   endfunction

   task automatic rand_pixel();
      int n, k;
      n = ($urandom_range(0, 39) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 5);
      for (k = 0; k < n; k++) send_layer(rand_layer(), k == n - 1);
   endtask

   task automatic rand_phase(int count);
      int start;
      start = sb.layers;
      while (sb.layers - start < count) rand_pixel();
   endtask

   task automatic directed();
      layer_type l;
      l = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, dslc_pkg::MODE_SCREEN};
      send_layer(l, 1);
      l = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, dslc_pkg::MODE_NORMAL};
      send_layer(l, 1);
      send_layer(l, 0);
      send_layer(l, 1);
      l = '{16'h8000, 16'h1234, 16'hFFFF, 16'h7FFF, 16'hFFFF, dslc_pkg::MODE_MULTIPLY};
      send_layer(l, 0);
      l = '{16'h00FF, 16'hFF00, 16'h5555, 16'hFFFF, 16'h0000, dslc_pkg::MODE_SCREEN};
      send_layer(l, 0);
      l = '{16'hAAAA, 16'h0001, 16'hFFFE, 16'h0001, 16'h8000, dslc_pkg::MODE_UNUSED};
      send_layer(l, 0);
      l = '{16'h4000, 16'hC000, 16'h2000, 16'h9000, 16'h8000, dslc_pkg::MODE_NORMAL};
      send_layer(l, 1);
      l = '{16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 16'h0005, dslc_pkg::MODE_NORMAL};
      send_layer(l, 0);
      l = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0005, dslc_pkg::MODE_MULTIPLY};
      send_layer(l, 0);
      l = '{16'h0000, 16'h0000, 16'hFFFF, 16'h8000, 16'h0005, dslc_pkg::MODE_SCREEN};
      send_layer(l, 1);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_invert(1'b0);
      directed();
      set_invert(1'b1);
      directed();
      set_invert(1'b0);
      rand_phase(500);
      // hold off the result side while more pixels are offered
      hold_left = 3000;
      repeat (25) rand_pixel();
      drain();
      set_invert(1'b1);
      rand_phase(600);
      set_invert(1'b0);
      idle_on = 1'b0;
      rand_phase(400);
      drain();
      repeat (2000) @(posedge clock);
      $display("covered %0d layers in %0d pixels, %0d with dropped layers, both sort orders",
               sb.layers, sb.pixels, sb.drop_pixels);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("depth_sorted_layer_compositor_test: done, clean");
      else
         $display("depth_sorted_layer_compositor_test: done, errors");
      $finish;
   end
endmodule
